/* rtl/core/tcpsat_pkg.sv */
// Shared types and constants for the TCP session ageing state table.
// No dependencies; the top, front end and back end import this package.
package tcpsat_pkg;

    localparam int SESSIONS      = 65536;
    localparam int PROTO_CLASSES = 4;
    localparam int ADDR_W        = $clog2(SESSIONS);
    localparam int SID_W         = 16;
    localparam int TMO_W         = 18;
    localparam int PC_W          = 2;
    localparam int IDLE_REGS     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    // table word: {timer running, session state}
    localparam int WORD_W        = 4;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_SETUP   = 3'd1,
        ST_ESTAB   = 3'd2,
        ST_HC_INIT = 3'd3,
        ST_HC_RESP = 3'd4,
        ST_CLOSE   = 3'd5
    } t_sess_state;

    typedef enum logic [1:0] {
        KIND_SETUP = 2'd0,
        KIND_IDLE  = 2'd1,
        KIND_HALF  = 2'd2,
        KIND_CLOSE = 2'd3
    } t_timer_kind;

    typedef enum logic [2:0] {
        EV_SYN    = 3'd0,
        EV_FIN    = 3'd1,
        EV_RST    = 3'd2,
        EV_OTHER  = 3'd3,
        EV_EXPIRY = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_EN   = 3'd0,
        CFG_SETUP_TMO  = 3'd1,
        CFG_HALF_TMO   = 3'd2,
        CFG_CLOSE_TMO  = 3'd3,
        CFG_IDLE_TMO0  = 3'd4,
        CFG_IDLE_TMO1  = 3'd5,
        CFG_IDLE_TMO2  = 3'd6,
        CFG_IDLE_TMO3  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

    // classified item as it sits in the queue
    typedef struct packed {
        logic [SID_W-1:0] sid;
        t_event           ev;
        logic             rev;
        logic [PC_W-1:0]  pc;    // already clamped to the last class
    } t_item;

    // back end to front end control
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

/* rtl/core/tcp_session_age_state_table_top.sv */
// Top level of the TCP session ageing state table: configuration registers,
// front end (classify and queue) and back end (state table and results).
// Depends on tcpsat_pkg, tcpsat_front, tcpsat_back, tcpsat_ram.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transfer per packet or
//    timer-expiry item. Items are classified at accept time (expiry on
//    i_action, then by TCP flags: SYN when tracking is on, FIN, RST, other)
//    and held in a two-entry queue.
//  - Output channel (o_out_valid / i_out_stall): exactly one result per
//    item, in item order, from a result register.
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx; write
//    only while the block is idle.
//  - Sequencing: the back end takes one item at a time, set by the
//    read-modify-write of the session table (registered read, then update
//    and write back); a result is loaded when the output register is free.
//  - Reset: after i_rst_n is released the back end sweeps the whole table,
//    SESSIONS (65536) entries, one entry per cycle, clearing state and timer
//    marks; o_in_stall stays high during that sweep. Config writes are taken.
//  - Receiver stall: the result register holds; the back end waits with its
//    read data; the queue keeps taking items until it is full.
module tcp_session_age_state_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_we,
    input  logic [tcpsat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcpsat_pkg::TMO_W-1:0]     i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic [tcpsat_pkg::SID_W-1:0]     i_session_id,
    input  logic [7:0]                       i_tcp_flags,
    input  logic                             i_reverse_flow,
    input  logic [tcpsat_pkg::PC_W-1:0]      i_proto_class,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tcpsat_pkg::SID_W-1:0]     o_session_out,
    output logic [2:0]                       o_new_state,
    output logic                             o_stop_timer,
    output logic                             o_start_timer,
    output logic [1:0]                       o_timer_kind,
    output logic [tcpsat_pkg::TMO_W-1:0]     o_timeout,
    output logic [2:0]                       o_event_class
);
    import tcpsat_pkg::*;

    // configuration registers
    logic               r_track_en;
    logic [TMO_W-1:0]   r_setup_tmo;
    logic [TMO_W-1:0]   r_half_tmo;
    logic [TMO_W-1:0]   r_close_tmo;
    logic [TMO_W-1:0]   r_idle_tmo [IDLE_REGS];

    t_back_ctl          ctl;
    t_item              head;
    logic               head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_en  <= 1'b0;
            r_setup_tmo <= '0;
            r_half_tmo  <= '0;
            r_close_tmo <= '0;
            for (int i = 0; i < IDLE_REGS; i++) begin
                r_idle_tmo[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRACK_EN:  r_track_en    <= i_cfg_data[0];
                CFG_SETUP_TMO: r_setup_tmo   <= i_cfg_data;
                CFG_HALF_TMO:  r_half_tmo    <= i_cfg_data;
                CFG_CLOSE_TMO: r_close_tmo   <= i_cfg_data;
                CFG_IDLE_TMO0: r_idle_tmo[0] <= i_cfg_data;
                CFG_IDLE_TMO1: r_idle_tmo[1] <= i_cfg_data;
                CFG_IDLE_TMO2: r_idle_tmo[2] <= i_cfg_data;
                CFG_IDLE_TMO3: r_idle_tmo[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcpsat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_session_id   (i_session_id),
        .i_tcp_flags    (i_tcp_flags),
        .i_reverse_flow (i_reverse_flow),
        .i_proto_class  (i_proto_class),
        .i_track_enable (r_track_en),
        .i_ctl          (ctl),
        .o_head_valid   (head_valid),
        .o_head         (head)
    );

    // head.pc is already clamped, so it selects a programmed idle timeout
    tcpsat_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_ctl         (ctl),
        .i_setup_tmo   (r_setup_tmo),
        .i_half_tmo    (r_half_tmo),
        .i_close_tmo   (r_close_tmo),
        .i_idle_tmo    (r_idle_tmo[head.pc]),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_session_out (o_session_out),
        .o_new_state   (o_new_state),
        .o_stop_timer  (o_stop_timer),
        .o_start_timer (o_start_timer),
        .o_timer_kind  (o_timer_kind),
        .o_timeout     (o_timeout),
        .o_event_class (o_event_class)
    );

endmodule

/* rtl/core/tcpsat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies; contents are undefined until written.
module tcpsat_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tcpsat_front.sv */
// Front end: accepts input transfers, classifies TCP flags, queues items.
// Depends on tcpsat_pkg.
module tcpsat_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [tcpsat_pkg::SID_W-1:0] i_session_id,
    input  logic [7:0]                   i_tcp_flags,
    input  logic                         i_reverse_flow,
    input  logic [tcpsat_pkg::PC_W-1:0]  i_proto_class,
    input  logic                         i_track_enable,
    input  tcpsat_pkg::t_back_ctl        i_ctl,
    output logic                         o_head_valid,
    output tcpsat_pkg::t_item            o_head
);
    import tcpsat_pkg::*;

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               accept;
    logic               pop;
    t_item              item;

    always_comb begin
        item.sid = i_session_id;
        item.rev = i_reverse_flow;
        if ({1'b0, i_proto_class} < (PC_W + 1)'(PROTO_CLASSES)) begin
            item.pc = i_proto_class;
        end else begin
            item.pc = PC_W'(PROTO_CLASSES - 1);
        end
        // priority: expiry, SYN (tracking on), FIN, RST, other
        if (i_action) begin
            item.ev = EV_EXPIRY;
        end else if (i_track_enable && i_tcp_flags[1]) begin
            item.ev = EV_SYN;
        end else if (i_tcp_flags[0]) begin
            item.ev = EV_FIN;
        end else if (i_tcp_flags[2]) begin
            item.ev = EV_RST;
        end else begin
            item.ev = EV_OTHER;
        end
    end

    assign o_in_stall = i_ctl.clearing || (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = i_ctl.pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (accept && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !accept) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

endmodule

/* rtl/core/tcpsat_back.sv */
// Back end: state table read-modify-write, transition logic, result register.
// Depends on tcpsat_pkg and tcpsat_ram.
module tcpsat_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  tcpsat_pkg::t_item            i_head,
    output tcpsat_pkg::t_back_ctl        o_ctl,
    input  logic [tcpsat_pkg::TMO_W-1:0] i_setup_tmo,
    input  logic [tcpsat_pkg::TMO_W-1:0] i_half_tmo,
    input  logic [tcpsat_pkg::TMO_W-1:0] i_close_tmo,
    input  logic [tcpsat_pkg::TMO_W-1:0] i_idle_tmo,   // already selected by class
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tcpsat_pkg::SID_W-1:0] o_session_out,
    output logic [2:0]                   o_new_state,
    output logic                         o_stop_timer,
    output logic                         o_start_timer,
    output logic [1:0]                   o_timer_kind,
    output logic [tcpsat_pkg::TMO_W-1:0] o_timeout,
    output logic [2:0]                   o_event_class
);
    import tcpsat_pkg::*;

    t_back_state        r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]  head_addr;
    logic [31:0]        sid_ext;
    logic               in_table;

    logic               out_free, load;
    logic [2:0]         cur, nst;
    logic               run, stop, start;
    t_timer_kind        kind;
    logic [TMO_W-1:0]   tmo;
    logic [2:0]         own, peer;

    logic               r_out_valid;
    logic [SID_W-1:0]   r_sid;
    logic [2:0]         r_new_state;
    logic               r_stop, r_start;
    logic [1:0]         r_kind;
    logic [TMO_W-1:0]   r_tmo;
    logic [2:0]         r_ev;

    assign sid_ext   = {{(32 - SID_W){1'b0}}, i_head.sid};
    assign head_addr = sid_ext[ADDR_W-1:0];
    assign in_table  = sid_ext < 32'(SESSIONS);
    assign out_free  = !r_out_valid || !i_out_stall;

    tcpsat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SESSIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (head_addr),
        .o_rdata (ram_rdata)
    );

    // transition for the item at the queue head; table word valid in BK_EXEC
    always_comb begin
        cur   = in_table ? ram_rdata[2:0] : ST_NONE;
        run   = ram_rdata[3];
        nst   = cur;
        stop  = 1'b0;
        start = 1'b0;
        kind  = KIND_SETUP;
        tmo   = '0;
        own   = i_head.rev ? ST_HC_RESP : ST_HC_INIT;
        peer  = i_head.rev ? ST_HC_INIT : ST_HC_RESP;
        if (in_table) begin
            case (i_head.ev)
                EV_EXPIRY: begin
                end
                EV_SYN: begin
                    if (cur != ST_SETUP) begin
                        nst   = ST_SETUP;
                        start = 1'b1;
                        kind  = KIND_SETUP;
                        tmo   = i_setup_tmo;
                    end
                end
                EV_FIN: begin
                    if (cur >= ST_ESTAB && cur != ST_CLOSE) begin
                        if (cur == peer) begin
                            nst   = ST_CLOSE;
                            start = 1'b1;
                            kind  = KIND_CLOSE;
                            tmo   = i_close_tmo;
                        end else if (cur != own) begin
                            nst   = own;
                            start = 1'b1;
                            kind  = KIND_HALF;
                            tmo   = i_half_tmo;
                        end
                        stop = start && run;
                    end
                end
                EV_RST: begin
                    if (cur != ST_CLOSE) begin
                        nst   = ST_CLOSE;
                        stop  = run;
                        start = 1'b1;
                        kind  = KIND_CLOSE;
                        tmo   = i_close_tmo;
                    end
                end
                default: begin
                    if (cur != ST_ESTAB) begin
                        nst   = ST_ESTAB;
                        start = 1'b1;
                        kind  = KIND_IDLE;
                        tmo   = i_idle_tmo;
                    end
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            BK_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_head_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = head_addr;
        ram_wdata    = {(start || (run && i_head.ev != EV_EXPIRY)), nst};
        load         = 1'b0;
        o_ctl.pop      = 1'b0;
        o_ctl.clearing = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = r_clr_addr;
                ram_wdata      = '0;
                o_ctl.clearing = 1'b1;
            end
            BK_IDLE: begin
                ram_re = i_head_valid;
            end
            BK_EXEC: begin
                if (out_free) begin
                    ram_we    = in_table;
                    load      = 1'b1;
                    o_ctl.pop = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sid       <= i_head.sid;
            r_new_state <= nst;
            r_stop      <= stop;
            r_start     <= start;
            r_kind      <= kind;
            r_tmo       <= tmo;
            r_ev        <= i_head.ev;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_session_out = r_sid;
    assign o_new_state   = r_new_state;
    assign o_stop_timer  = r_stop;
    assign o_start_timer = r_start;
    assign o_timer_kind  = r_kind;
    assign o_timeout     = r_tmo;
    assign o_event_class = r_ev;

    a_stop_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stop |-> r_start)
        else $error("stop reported without a start");

    a_expiry_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ev == EV_EXPIRY |-> !r_start && !r_stop && r_tmo == '0)
        else $error("expiry result carries a timer action");

    a_close_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_start && r_kind == KIND_CLOSE |-> r_new_state == ST_CLOSE)
        else $error("close timer without close state");

    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CLEAR |-> !o_ctl.pop && !load)
        else $error("item retired during table clear");

    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EXEC && $past(r_state) == BK_IDLE |-> $past(ram_re))
        else $error("table word used without a read");

endmodule
